@@ sv/sltc_pkg.sv @@
// Package with token kinds, scan modes and character tables for the lexer.
`default_nettype none
package sltc_pkg;

  localparam int MAX_WORD_DEF    = 80;
  localparam int OFFSET_BITS_DEF = 16;
  localparam int KIND_W  = 6;
  localparam int START_W = 16;
  localparam int LEN_W   = 7;
  localparam int NKW     = 10;
  localparam int QDEPTH  = 4;

  localparam logic [KIND_W-1:0] K_END   = 6'd0;
  localparam logic [KIND_W-1:0] K_ERROR = 6'd1;
  localparam logic [KIND_W-1:0] K_BOOL  = 6'd32;
  localparam logic [KIND_W-1:0] K_IDENT = 6'd33;
  localparam logic [KIND_W-1:0] K_FLOAT = 6'd34;
  localparam logic [KIND_W-1:0] K_NUM   = 6'd35;
  localparam logic [KIND_W-1:0] K_KW0   = 6'd24;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_HOLD  = 3'd1,
    M_WORD  = 3'd2,
    M_LINE  = 3'd3,
    M_BLOCK = 3'd4,
    M_DROP  = 3'd5
  } mode_t;

  // One token as it leaves the front end.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic               last;
  } tok_t;

  // Keyword text, eight characters per entry, first character lowest.
  localparam logic [63:0] KW_TEXT [NKW] = '{
    64'h0065_7261_6c63_6564,  // declare
    64'h0000_0000_0000_6669,  // if
    64'h0000_0065_6c69_6877,  // while
    64'h0065_6475_6c63_6e69,  // include
    64'h006d_6172_676f_7270,  // program
    64'h6e6f_6974_636e_7566,  // function
    64'h0000_0000_0077_656e,  // new
    64'h0000_6e72_7574_6572,  // return
    64'h0000_0000_6575_7274,  // true
    64'h0000_0065_736c_6166   // false
  };
  localparam logic [3:0] KW_LEN [NKW] = '{4'd7, 4'd2, 4'd5, 4'd7, 4'd7,
                                          4'd8, 4'd3, 4'd6, 4'd4, 4'd5};

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    k = 6'd0;
    case (c)
      8'h2a: k = 6'd2;
      8'h2f: k = 6'd3;
      8'h2b: k = 6'd4;
      8'h2d: k = 6'd5;
      8'h3e: k = 6'd6;
      8'h3c: k = 6'd7;
      8'h21: k = 6'd8;
      8'h28: k = 6'd9;
      8'h29: k = 6'd10;
      8'h3d: k = 6'd11;
      8'h2c: k = 6'd12;
      8'h3b: k = 6'd13;
      8'h7b: k = 6'd14;
      8'h7d: k = 6'd15;
      8'h5b: k = 6'd16;
      8'h5d: k = 6'd17;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

  function automatic logic holdable(input logic [7:0] c);
    return c == 8'h2f || c == 8'h3e || c == 8'h3c || c == 8'h3d ||
           c == 8'h21 || c == 8'h26 || c == 8'h7c;
  endfunction

  function automatic logic [KIND_W-1:0] double_kind(input logic [7:0] h,
                                                     input logic [7:0] c);
    logic [KIND_W-1:0] k;
    k = 6'd0;
    if (c == 8'h3d) begin
      if (h == 8'h3e) k = 6'd18;
      else if (h == 8'h3c) k = 6'd19;
      else if (h == 8'h3d) k = 6'd20;
      else if (h == 8'h21) k = 6'd21;
    end
    if (c == 8'h26 && h == 8'h26) k = 6'd22;
    if (c == 8'h7c && h == 8'h7c) k = 6'd23;
    return k;
  endfunction

endpackage
`default_nettype wire

@@ sv/sltc_front.sv @@
// Front end: scans one byte per cycle while step is high and produces up to three tokens.
`default_nettype none
module sltc_front #(
  parameter int MAX_WORD    = sltc_pkg::MAX_WORD_DEF,
  parameter int OFFSET_BITS = sltc_pkg::OFFSET_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    c,
  input  wire logic          fin,
  output sltc_pkg::tok_t     tok [3],
  output logic [1:0]         ntok
);

  localparam int NKW = sltc_pkg::NKW;
  localparam int LW  = sltc_pkg::LEN_W;

  sltc_pkg::mode_t        mode_r, mode_nxt;
  logic [7:0]             held_r, held_nxt;
  logic [OFFSET_BITS-1:0] hoff_r, hoff_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [LW-1:0]          wlen_r, wlen_nxt;
  logic [NKW-1:0]         kwm_r, kwm_nxt;
  logic [5:0]             wcf_r, wcf_nxt;

  // Working copies used while the byte is processed.
  sltc_pkg::mode_t        m;
  logic [7:0]             h;
  logic [OFFSET_BITS-1:0] ho;
  logic [LW-1:0]          wl;
  logic [NKW-1:0]         kw;
  logic [5:0]             wf;
  logic [1:0]             n;
  logic [OFFSET_BITS-1:0] pos1;
  logic                   ok;

  function automatic logic [sltc_pkg::START_W-1:0] off16(
      input logic [OFFSET_BITS-1:0] o);
    logic [31:0] t;
    t = 32'(o);
    return t[sltc_pkg::START_W-1:0];
  endfunction

  always_comb begin
    m = mode_r; h = held_r; ho = hoff_r; wl = wlen_r; kw = kwm_r; wf = wcf_r;
    n = 2'd0; ok = 1'b1;
    pos1 = pos_r + 1'b1;
    for (int i = 0; i < 3; i++) tok[i] = '0;

    // A byte is handled in up to two passes (a held byte re-entering as a
    // word or the current byte after a flushed operator), inlined below.
    unique case (mode_r)
      sltc_pkg::M_HOLD: begin
        if (h == 8'h2f && c == 8'h2a) begin
          m = sltc_pkg::M_BLOCK; h = 8'h2a;
        end else if (h == 8'h2f && c == 8'h2f) begin
          m = sltc_pkg::M_LINE;
        end else if (sltc_pkg::double_kind(h, c) != '0) begin
          tok[n] = '{sltc_pkg::double_kind(h, c), off16(ho), LW'(2), 1'b0};
          n = n + 1'b1; m = sltc_pkg::M_IDLE;
        end else if (sltc_pkg::single_kind(h) != '0) begin
          tok[n] = '{sltc_pkg::single_kind(h), off16(ho), LW'(1), 1'b0};
          n = n + 1'b1; m = sltc_pkg::M_IDLE;
          do_idle();
        end else begin
          start_word(h, ho);
          do_word();
        end
      end
      sltc_pkg::M_WORD: do_word();
      sltc_pkg::M_LINE: if (c == 8'h0a || c == 8'h0d) m = sltc_pkg::M_IDLE;
      sltc_pkg::M_BLOCK: begin
        if (h == 8'h2a && c == 8'h2f) m = sltc_pkg::M_IDLE;
        else h = c;
      end
      sltc_pkg::M_DROP: ;
      default: do_idle();
    endcase

    if (fin) begin
      if (m == sltc_pkg::M_HOLD) begin
        if (sltc_pkg::single_kind(h) != '0) begin
          tok[n] = '{sltc_pkg::single_kind(h), off16(ho), LW'(1), 1'b0};
          n = n + 1'b1;
        end else begin
          start_word(h, ho);
          finish_word();
        end
      end else if (m == sltc_pkg::M_WORD) begin
        finish_word();
      end
      tok[n] = '{sltc_pkg::K_END, off16(pos1), LW'(0), 1'b0};
      n = n + 1'b1;
    end
    if (n != 2'd0) tok[n - 1'b1].last = 1'b1;
    ntok = n;

    if (fin) begin
      mode_nxt = sltc_pkg::M_IDLE; held_nxt = '0; hoff_nxt = '0; pos_nxt = '0;
      wlen_nxt = '0; kwm_nxt = '1; wcf_nxt = '0;
    end else begin
      mode_nxt = m; held_nxt = h; hoff_nxt = ho; pos_nxt = pos1;
      wlen_nxt = wl; kwm_nxt = kw; wcf_nxt = wf;
    end
  end

  // The helpers below act on the working copies of the combinational block.
  function automatic void word_add(input logic [7:0] ch);
    logic id, dg, dp, ft;
    logic [1:0] pts;
    if (32'(wl) >= MAX_WORD) begin
      ok = 1'b0;
    end else begin
      ok = 1'b1;
      for (int i = 0; i < NKW; i++)
        if (wl >= LW'(sltc_pkg::KW_LEN[i]) || wl > LW'(7) ||
            sltc_pkg::KW_TEXT[i][8*wl[2:0] +: 8] != ch)
          kw[i] = 1'b0;
      id  = (wl == '0) ? sltc_pkg::is_letter(ch)
                       : (wf[0] && (sltc_pkg::is_letter(ch) || sltc_pkg::is_digit(ch)));
      dg  = wf[1] && sltc_pkg::is_digit(ch);
      ft  = wf[2] && (ch == 8'h66 || ch == 8'h46);
      dp  = wf[2] && (sltc_pkg::is_digit(ch) || ch == 8'h2e);
      pts = wf[4:3];
      if (ch == 8'h2e && pts < 2'd2) pts = pts + 1'b1;
      wf = {ft, pts, dp, dg, id};
      wl = wl + 1'b1;
    end
  endfunction

  function automatic void start_word(input logic [7:0] ch,
                                     input logic [OFFSET_BITS-1:0] o);
    m = sltc_pkg::M_WORD; ho = o; wl = '0; wf = 6'd7; kw = '1;
    word_add(ch);
  endfunction

  function automatic void finish_word();
    logic [sltc_pkg::KIND_W-1:0] kd;
    kd = sltc_pkg::K_ERROR;
    for (int i = NKW - 1; i >= 0; i--)
      if (kw[i] && LW'(sltc_pkg::KW_LEN[i]) == wl)
        kd = (i < 8) ? sltc_pkg::K_KW0 + sltc_pkg::KIND_W'(i) : sltc_pkg::K_BOOL;
    if (kd == sltc_pkg::K_ERROR && wl != '0) begin
      if (wf[0]) kd = sltc_pkg::K_IDENT;
      else if ((wf[2] && wf[4:3] == 2'd1) || wf[5]) kd = sltc_pkg::K_FLOAT;
      else if (wf[1]) kd = sltc_pkg::K_NUM;
    end
    tok[n] = '{kd, off16(ho), wl, 1'b0};
    n = n + 1'b1;
    m = (kd == sltc_pkg::K_ERROR) ? sltc_pkg::M_DROP : sltc_pkg::M_IDLE;
  endfunction

  function automatic void do_idle();
    if (sltc_pkg::is_ws(c)) begin
    end else if (sltc_pkg::holdable(c)) begin
      m = sltc_pkg::M_HOLD; h = c; ho = pos_r;
    end else if (sltc_pkg::single_kind(c) != '0) begin
      tok[n] = '{sltc_pkg::single_kind(c), off16(pos_r), LW'(1), 1'b0};
      n = n + 1'b1;
    end else begin
      start_word(c, pos_r);
    end
  endfunction

  function automatic void do_word();
    if (sltc_pkg::is_ws(c)) begin
      finish_word();
    end else if (sltc_pkg::single_kind(c) != '0) begin
      finish_word();
      if (m == sltc_pkg::M_IDLE) do_idle();
    end else begin
      word_add(c);
      if (!ok) begin
        tok[n] = '{sltc_pkg::K_ERROR, off16(ho), wl, 1'b0};
        n = n + 1'b1;
        m = sltc_pkg::M_DROP;
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sltc_pkg::M_IDLE;
      held_r <= '0;
      hoff_r <= '0;
      pos_r  <= '0;
      wlen_r <= '0;
      kwm_r  <= '1;
      wcf_r  <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      hoff_r <= hoff_nxt;
      pos_r  <= pos_nxt;
      wlen_r <= wlen_nxt;
      kwm_r  <= kwm_nxt;
      wcf_r  <= wcf_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/sltc_queue.sv @@
// Token queue between front end and output: up to three writes, one read.
`default_nettype none
module sltc_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  sltc_pkg::tok_t wr_tok [3],
  input  wire logic [1:0] wr_n,
  output logic           room3,
  output sltc_pkg::tok_t rd_tok,
  output logic           rd_valid,
  input  wire logic      rd_take
);

  localparam int D  = sltc_pkg::QDEPTH * 2;
  localparam int AW = $clog2(D);

  sltc_pkg::tok_t mem_r [D];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;

  assign rd_valid = cnt_r != '0;
  assign rd_tok   = mem_r[rp_r];
  assign room3    = cnt_r + (AW+1)'(3) <= (AW+1)'(D) - (rd_valid ? (AW+1)'(0) : (AW+1)'(0));

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      if (2'(i) < wr_n) mem_r[wp_r + AW'(i)] <= wr_tok[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(wr_n);
      rp_r  <= rp_r + AW'(rd_take && rd_valid);
      cnt_r <= cnt_r + (AW+1)'(wr_n) - (AW+1)'(rd_take && rd_valid);
    end
  end

endmodule
`default_nettype wire

@@ sv/script_lexer_token_classifier.sv @@
// Top level of the streaming script lexer and token classifier.
// Source text enters one byte per word on the in_ channel, with in_tlast
// marking the final byte of a text. A front end classifies each byte as it
// is taken and may produce up to three tokens (a finished word, an operator and
// the end token); these go into an eight-entry token queue, from which the
// out_ channel delivers one token per cycle while out_tready is high. A byte
// is taken every cycle while the queue has room for three tokens, so a steady
// one byte per cycle holds as long as the consumer keeps up; the queue
// occupancy sets the stall. The tokens caused by a byte enter the queue when
// it is taken and reach out_ behind earlier ones. out_tlast marks the last
// token from one input byte. Offsets restart at zero after each final byte.
`default_nettype none
module script_lexer_token_classifier #(
  parameter int MAX_WORD    = sltc_pkg::MAX_WORD_DEF,
  parameter int OFFSET_BITS = sltc_pkg::OFFSET_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_in
  input  wire logic        in_tlast,   // final_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [5:0] token_kind, [21:6] token_start,
                                       // [28:22] token_length, zero fill
  output logic             out_tlast   // run_last
);

  sltc_pkg::tok_t ftok [3];
  sltc_pkg::tok_t qtok;
  logic [1:0]     fn;
  logic           room3, step;

  assign step      = in_tvalid && in_tready;
  assign in_tready = room3;

  sltc_front #(.MAX_WORD(MAX_WORD), .OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk, .rst_n, .step, .c(in_tdata), .fin(in_tlast), .tok(ftok), .ntok(fn)
  );

  sltc_queue u_queue (
    .clk, .rst_n, .wr_tok(ftok), .wr_n(step ? fn : 2'd0), .room3,
    .rd_tok(qtok), .rd_valid(out_tvalid), .rd_take(out_tready)
  );

  assign out_tdata = {3'b000, qtok.len, qtok.start, qtok.kind};
  assign out_tlast = qtok.last;

endmodule
`default_nettype wire

@@ bench/lexer_checker.sv @@
// Checker that predicts the lexer's tokens from accepted source bytes and compares them.
module lexer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          tokens_pending,
  output int          tokens_seen,
  output int          texts_seen
);

  localparam int WORD_LIMIT = sltc_pkg::MAX_WORD_DEF;
  localparam int KW_N = sltc_pkg::NKW;
  localparam int KW   = sltc_pkg::KIND_W;

  typedef struct {
    logic [KW-1:0]                kind;
    logic [sltc_pkg::START_W-1:0] start;
    logic [sltc_pkg::LEN_W-1:0]   len;
    logic                         last;
  } token_t;

  token_t token_q[$];

  // Shadow copy of the lexer state.
  sltc_pkg::mode_t    lx_mode;
  logic [7:0]         lx_held;
  logic [15:0]        lx_hoff;
  logic [15:0]        lx_pos;
  logic [6:0]         lx_wlen;
  logic [KW_N-1:0]    lx_kwm;
  logic [5:0]         lx_cls;
  int                 step_count;

  function automatic logic blank(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0d;
  endfunction

  function automatic logic digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [KW-1:0] op_kind(input logic [7:0] c);
    case (c)
      "*": return 6'd2;
      "/": return 6'd3;
      "+": return 6'd4;
      "-": return 6'd5;
      ">": return 6'd6;
      "<": return 6'd7;
      "!": return 6'd8;
      "(": return 6'd9;
      ")": return 6'd10;
      "=": return 6'd11;
      ",": return 6'd12;
      ";": return 6'd13;
      "{": return 6'd14;
      "}": return 6'd15;
      "[": return 6'd16;
      "]": return 6'd17;
      default: return 6'd0;
    endcase
  endfunction

  // Characters that may start a two-character operator or comment opener.
  function automatic logic may_pair(input logic [7:0] c);
    return c == "/" || c == ">" || c == "<" || c == "=" || c == "!" ||
           c == "&" || c == "|";
  endfunction

  function automatic logic [KW-1:0] pair_kind(input logic [7:0] h,
                                               input logic [7:0] c);
    if (c == "=" && h == ">") return 6'd18;
    if (c == "=" && h == "<") return 6'd19;
    if (c == "=" && h == "=") return 6'd20;
    if (c == "=" && h == "!") return 6'd21;
    if (c == "&" && h == "&") return 6'd22;
    if (c == "|" && h == "|") return 6'd23;
    return 6'd0;
  endfunction

  task push_token(input logic [KW-1:0] k, input logic [15:0] s,
                  input logic [6:0] l);
    token_q.push_back('{k, s, l, 1'b0});
    step_count++;
  endtask

  // Adds one character to the open word; returns 0 when the word is full.
  function logic grow_word(input logic [7:0] c);
    int n;
    logic ident, dig, dp, ft;
    logic [1:0] pts;
    n = lx_wlen;
    if (n >= WORD_LIMIT) return 1'b0;
    for (int i = 0; i < KW_N; i++)
      if (n >= sltc_pkg::KW_LEN[i] || sltc_pkg::KW_TEXT[i][8*n +: 8] != c)
        lx_kwm[i] = 1'b0;
    ident = (n == 0) ? letter(c) : (lx_cls[0] && (letter(c) || digit(c)));
    dig   = lx_cls[1] && digit(c);
    ft    = lx_cls[2] && (c == "f" || c == "F");
    dp    = lx_cls[2] && (digit(c) || c == ".");
    pts   = lx_cls[4:3];
    if (c == "." && pts < 2) pts++;
    lx_cls  = {ft, pts, dp, dig, ident};
    lx_wlen = 7'(n + 1);
    return 1'b1;
  endfunction

  task open_word(input logic [7:0] c, input logic [15:0] off);
    lx_mode = sltc_pkg::M_WORD;
    lx_hoff = off;
    lx_wlen = '0;
    lx_cls  = 6'd7;
    lx_kwm  = '1;
    void'(grow_word(c));
  endtask

  task close_word();
    logic [KW-1:0] k;
    k = sltc_pkg::K_ERROR;
    for (int i = 0; i < KW_N; i++)
      if (k == sltc_pkg::K_ERROR && lx_kwm[i] && sltc_pkg::KW_LEN[i] == lx_wlen)
        k = (i < 8) ? sltc_pkg::K_KW0 + KW'(i) : sltc_pkg::K_BOOL;
    if (k == sltc_pkg::K_ERROR && lx_wlen > 0) begin
      if (lx_cls[0]) k = sltc_pkg::K_IDENT;
      else if ((lx_cls[2] && lx_cls[4:3] == 2'd1) || lx_cls[5]) k = sltc_pkg::K_FLOAT;
      else if (lx_cls[1]) k = sltc_pkg::K_NUM;
    end
    push_token(k, lx_hoff, lx_wlen);
    lx_mode = (k == sltc_pkg::K_ERROR) ? sltc_pkg::M_DROP : sltc_pkg::M_IDLE;
  endtask

  task idle_char(input logic [7:0] c, input logic [15:0] pos);
    logic [KW-1:0] k;
    k = op_kind(c);
    if (blank(c)) return;
    if (may_pair(c)) begin
      lx_mode = sltc_pkg::M_HOLD;
      lx_held = c;
      lx_hoff = pos;
    end else if (k != 0) begin
      push_token(k, pos, 7'd1);
    end else begin
      open_word(c, pos);
    end
  endtask

  task word_char(input logic [7:0] c, input logic [15:0] pos);
    if (blank(c)) begin
      close_word();
    end else if (op_kind(c) != 0) begin
      close_word();
      if (lx_mode == sltc_pkg::M_IDLE) idle_char(c, pos);
    end else if (!grow_word(c)) begin
      push_token(sltc_pkg::K_ERROR, lx_hoff, lx_wlen);
      lx_mode = sltc_pkg::M_DROP;
    end
  endtask

  task clear_state();
    lx_mode = sltc_pkg::M_IDLE;
    lx_held = '0;
    lx_hoff = '0;
    lx_pos  = '0;
    lx_wlen = '0;
    lx_kwm  = '1;
    lx_cls  = '0;
  endtask

  // Works out the tokens caused by one accepted byte.
  task lex_byte(input logic [7:0] c, input logic fin);
    logic [15:0] pos;
    logic [7:0]  h;
    logic [KW-1:0] k;
    pos = lx_pos;
    h = lx_held;
    step_count = 0;
    case (lx_mode)
      sltc_pkg::M_HOLD: begin
        if (h == "/" && c == "*") begin
          lx_mode = sltc_pkg::M_BLOCK;
          lx_held = "*";
        end else if (h == "/" && c == "/") begin
          lx_mode = sltc_pkg::M_LINE;
        end else if (pair_kind(h, c) != 0) begin
          push_token(pair_kind(h, c), lx_hoff, 7'd2);
          lx_mode = sltc_pkg::M_IDLE;
        end else if (op_kind(h) != 0) begin
          push_token(op_kind(h), lx_hoff, 7'd1);
          lx_mode = sltc_pkg::M_IDLE;
          idle_char(c, pos);
        end else begin
          open_word(h, lx_hoff);
          word_char(c, pos);
        end
      end
      sltc_pkg::M_WORD: word_char(c, pos);
      sltc_pkg::M_LINE: if (c == 8'h0a || c == 8'h0d) lx_mode = sltc_pkg::M_IDLE;
      sltc_pkg::M_BLOCK: begin
        if (lx_held == "*" && c == "/") lx_mode = sltc_pkg::M_IDLE;
        else lx_held = c;
      end
      sltc_pkg::M_DROP: ;
      default: idle_char(c, pos);
    endcase
    if (fin) begin
      if (lx_mode == sltc_pkg::M_HOLD) begin
        k = op_kind(lx_held);
        if (k != 0) begin
          push_token(k, lx_hoff, 7'd1);
        end else begin
          open_word(lx_held, lx_hoff);
          close_word();
        end
      end else if (lx_mode == sltc_pkg::M_WORD) begin
        close_word();
      end
      push_token(sltc_pkg::K_END, pos + 16'd1, 7'd0);
      clear_state();
      texts_seen++;
    end else begin
      lx_pos = pos + 16'd1;
    end
    if (step_count > 0) token_q[token_q.size()-1].last = 1'b1;
  endtask

  task report(input string what, input logic [31:0] got, input logic [31:0] want);
    fail_count++;
    if (fail_count <= 30)
      $display("mismatch on token %0d: %s got %0d expected %0d",
               tokens_seen, what, got, want);
  endtask

  initial begin
    fail_count = 0;
    tokens_seen = 0;
    texts_seen = 0;
    tokens_pending = 0;
    clear_state();
  end

  always @(posedge clk) begin
    token_t want;
    if (!rst_n) begin
      clear_state();
      token_q.delete();
    end else begin
      if (in_tvalid && in_tready) lex_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (token_q.size() == 0) begin
          report("token with none expected, kind", 32'(out_tdata[5:0]), 32'd0);
        end else begin
          want = token_q.pop_front();
          if (out_tdata[5:0] != want.kind)
            report("kind", 32'(out_tdata[5:0]), 32'(want.kind));
          if (out_tdata[21:6] != want.start)
            report("start", 32'(out_tdata[21:6]), 32'(want.start));
          if (out_tdata[28:22] != want.len)
            report("length", 32'(out_tdata[28:22]), 32'(want.len));
          if (out_tlast != want.last)
            report("last flag", 32'(out_tlast), 32'(want.last));
        end
        tokens_seen++;
      end
    end
    tokens_pending = token_q.size();
  end

endmodule

@@ bench/testbench.sv @@
// Top of the lexer bench: clock, reset, source text stimulus and the verdict.
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TARGET_BYTES = 450;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // [7:0] char_in
  logic        in_tlast = 1'b0;   // final_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [5:0] kind, [21:6] start, [28:22] length
  logic        out_tlast;

  int fail_count, tokens_pending, tokens_seen, texts_seen;
  int cycle_count = 0;
  int bytes_sent = 0;
  int burst_left = 0;
  logic [7:0] text_q[$];

  script_lexer_token_classifier dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  lexer_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast),
    .fail_count(fail_count), .tokens_pending(tokens_pending),
    .tokens_seen(tokens_seen), .texts_seen(texts_seen)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[script_lexer_token_classifier] ERROR");
      $finish;
    end
  end

  // The receiver is always ready, half ready or mostly stalled, with the
  // style picked at random periodically. Once, early in the random part, it
  // holds off long so that the token queue fills and the lexer stalls its input.
  int rx_cycle = 0;
  int rx_style = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_style <= $urandom_range(0, 2);
      if (rx_cycle == 300) hold_left <= 200;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      if (hold_left > 0 || rx_cycle == 300) out_tready <= 1'b0;
      else if (rx_style == 0) out_tready <= 1'b1;
      else if (rx_style == 1) out_tready <= 1'($urandom_range(0, 1));
      else out_tready <= ($urandom_range(0, 3) == 0);
    end
  end

  // Offers one byte and waits for the handshake. Ready is sampled at the
  // falling edge so the decision never races the lexer's own update.
  task send_byte(input logic [7:0] c, input logic fin);
    logic ok;
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= fin;
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    bytes_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Sends the collected text; its last byte carries the final-byte flag.
  task send_text();
    for (int i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task add_word_chars(input int n, input int digits_only);
    for (int i = 0; i < n; i++)
      if (digits_only) text_q.push_back(8'("0" + $urandom_range(0, 9)));
      else if (i > 0 && $urandom_range(0, 3) == 0)
        text_q.push_back(8'("0" + $urandom_range(0, 9)));
      else text_q.push_back(8'("a" + $urandom_range(0, 25)));
  endtask

  // Appends one random lexical element, mostly well formed.
  task add_piece();
    string kw[10] = '{"declare", "if", "while", "include", "program",
                      "function", "new", "return", "true", "false"};
    string pairs[8] = '{">=", "<=", "==", "!=", "&&", "||", "|&", "&"};
    string ops = "*/+-><!()=,;{}[]";
    case ($urandom_range(0, 15))
      0, 1: add_text(kw[$urandom_range(0, 9)]);
      2, 3: add_word_chars($urandom_range(1, 8), 0);
      4: add_word_chars($urandom_range(1, 6), 1);
      5: begin
        add_word_chars($urandom_range(1, 3), 1);
        if ($urandom_range(0, 1)) add_text(".");
        add_word_chars($urandom_range(0, 2), 1);
        if ($urandom_range(0, 1)) add_text($urandom_range(0, 1) ? "f" : "F");
      end
      6, 7: text_q.push_back(ops[$urandom_range(0, 15)]);
      8: add_text(pairs[$urandom_range(0, 7)]);
      9: begin
        add_text("//");
        add_word_chars($urandom_range(0, 4), 0);
        if ($urandom_range(0, 3) != 0) text_q.push_back($urandom_range(0, 1) ? 8'h0a : 8'h0d);
      end
      10: begin
        add_text("/*");
        for (int i = $urandom_range(0, 5); i > 0; i--)
          text_q.push_back($urandom_range(0, 1) ? 8'h2a : 8'("a" + $urandom_range(0, 3)));
        if ($urandom_range(0, 3) != 0) add_text("*/");
      end
      11: text_q.push_back(8'($urandom_range(0, 255)));
      12: begin
        // A word near or over the length limit now and then; otherwise a word of dots.
        if ($urandom_range(0, 7) == 0) add_word_chars($urandom_range(79, 84), 0);
        else add_text($urandom_range(0, 1) ? "1.2.3" : ".5");
      end
      default: text_q.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
    endcase
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed texts: a float, a number with a trailing f, two-character
    // operators, the star-slash that closes its own comment, a line comment,
    // a pipe before an ampersand, an operator held at the final byte and a
    // byte with every bit set.
    add_text("x9>=3.5/*/ 7f;");
    send_text();
    add_text("//c");
    text_q.push_back(8'h0a);
    add_text("&&||!=<=|&");
    send_text();
    add_text("/");
    send_text();
    text_q.push_back(8'hff);
    send_text();

    while (bytes_sent < TARGET_BYTES) begin
      for (int i = $urandom_range(1, 12); i > 0; i--) begin
        add_piece();
        if ($urandom_range(0, 2) != 0) text_q.push_back(8'h20);
      end
      send_text();
    end
    in_tvalid <= 1'b0;

    while (tokens_pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d source bytes in %0d texts; compared %0d tokens.",
             bytes_sent, texts_seen, tokens_seen);
    if (fail_count == 0 && tokens_pending == 0) begin
      $display("[script_lexer_token_classifier] OK");
    end else begin
      $display("[script_lexer_token_classifier] ERROR");
    end
    $finish;
  end

endmodule
